// ----- rtl/core/glm_pkg.sv -----
// shared constants, register codes and control types of the grid local maximum finder
package glm_pkg;

    // configuration register widths and reset values
    localparam int GRID_WIDTH_W  = 11;
    localparam int GRID_HEIGHT_W = 16;
    localparam int ROW_W         = 16;
    localparam int RESET_WIDTH   = 1024;
    localparam int RESET_HEIGHT  = 1024;

    // configuration port layout
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1
    } t_cfg_reg;

    // per-word control carried from the input stage to the peak test
    typedef struct packed {
        logic             valid;
        logic             testable;
        logic [ROW_W-1:0] row;
    } t_item_ctl;

endpackage

// ----- rtl/core/glm_ifs.sv -----
// valid/ready channel interfaces for samples, peaks and configuration writes
interface glm_sample_if
    import glm_pkg::*;
#(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] sample_value;

    modport source(output valid, output sample_value, input ready);
    modport sink(input valid, input sample_value, output ready);
endinterface

interface glm_peak_if
    import glm_pkg::*;
#(
    parameter int COL_BITS   = 10,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [COL_BITS-1:0]   peak_column;
    logic [ROW_W-1:0]      peak_row;
    logic [VALUE_BITS-1:0] peak_value;

    modport source(output valid, output peak_column, output peak_row, output peak_value,
                   input ready);
    modport sink(input valid, input peak_column, input peak_row, input peak_value,
                 output ready);
endinterface

interface glm_cfg_if
    import glm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/glm_line_store.sv -----
// dual row line store: one word per column holding the older and newer row side by side
module glm_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 64
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  logic [DW-1:0]   i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output logic [DW-1:0]   o_rdata,
    input  logic [AW-1:0]   i_raddr_next,
    output logic [DW/2-1:0] o_rdata_next
);

    logic [DW-1:0]   r_mem [DEPTH];
    logic [DW-1:0]   r_rdata;
    logic [DW/2-1:0] r_rdata_next;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports: full word at the column, newer half at the next column
    always_ff @(posedge i_clk) begin
        r_rdata      <= r_mem[i_raddr];
        r_rdata_next <= r_mem[i_raddr_next][DW/2-1:0];
    end

    assign o_rdata      = r_rdata;
    assign o_rdata_next = r_rdata_next;

endmodule

// ----- rtl/core/glm_peak_test.sv -----
// four-neighbor strict maximum compare, left neighbor kept from the previous word
module glm_peak_test
    import glm_pkg::*;
#(
    parameter int CW         = 10,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  t_item_ctl             i_ctl,
    input  logic [CW-1:0]         i_col,
    input  logic [VALUE_BITS-1:0] i_bottom,
    input  logic [VALUE_BITS-1:0] i_centre,
    input  logic [VALUE_BITS-1:0] i_top,
    input  logic [VALUE_BITS-1:0] i_right,
    output logic                  o_push,
    output logic [CW-1:0]         o_peak_col,
    output logic [ROW_W-1:0]      o_peak_row,
    output logic [VALUE_BITS-1:0] o_peak_value
);

    logic [VALUE_BITS-1:0] r_left;
    logic                  is_max;

    // middle row of the previous column becomes the left neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_left <= i_centre;
        end
    end

    // center above the incoming word against its four neighbors
    assign is_max = (i_centre != '0) && (i_centre > r_left) && (i_centre > i_right) &&
                    (i_centre > i_top) && (i_centre > i_bottom);

    assign o_push       = i_ctl.valid && i_ctl.testable && is_max;
    assign o_peak_col   = i_col;
    assign o_peak_row   = i_ctl.row;
    assign o_peak_value = i_centre;

endmodule

// ----- rtl/core/glm_result_fifo.sv -----
// small result queue that decouples the peak test from output back pressure
module glm_result_fifo #(
    parameter int DW    = 58,
    parameter int DEPTH = 4,
    parameter int PW    = 2,
    parameter int CNTW  = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [DW-1:0]   i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output logic [DW-1:0]   o_data,
    output logic [CNTW-1:0] o_count
);

    logic [DW-1:0]   r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic            do_pop;

    assign do_pop = i_pop && (r_count != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CNTW'(i_push) - CNTW'(do_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ----- rtl/core/grid_local_maximum_finder_unit.sv -----
// grid local maximum finder: raster sample stream in, four-neighbor strict peaks out
// a peak word is offered from the result queue once the input stage has registered the sample below its center
// throughput: one sample per cycle; input waits only while the result queue is near full
// reset: counters to zero, width and height to 1024, result queue empty; line stores
// are not cleared and hold whatever was last written
module grid_local_maximum_finder_unit
    import glm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    glm_sample_if.sink   i_sample,
    glm_peak_if.source   o_peak,
    glm_cfg_if.sink      i_cfg
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNTW  = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W      = CW + ROW_W + VALUE_BITS;

    // last column index for a programmed width, clamped to the supported range
    function automatic logic [CW-1:0] calc_last_col(input logic [GRID_WIDTH_W-1:0] w);
        logic [31:0] wx;
        wx = 32'(w);
        if (wx < 32'd3) begin
            return CW'(2);
        end else if (wx > 32'(MAX_WIDTH)) begin
            return CW'(MAX_WIDTH - 1);
        end else begin
            return CW'(wx - 32'd1);
        end
    endfunction

    // last row index for a programmed height
    function automatic logic [ROW_W-1:0] calc_last_row(input logic [GRID_HEIGHT_W-1:0] h);
        if (h < GRID_HEIGHT_W'(3)) begin
            return ROW_W'(2);
        end else begin
            return ROW_W'(h - GRID_HEIGHT_W'(1));
        end
    endfunction

    logic [CW-1:0]           r_last_col;
    logic [ROW_W-1:0]        r_last_row;
    logic [CW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    t_item_ctl               r_s1_ctl;
    logic [CW-1:0]           r_s1_col;
    logic [VALUE_BITS-1:0]   r_s1_sample;
    logic                    in_accept;
    logic                    cfg_accept;
    logic [CW-1:0]           next_col;
    logic [2*VALUE_BITS-1:0] store_rdata;
    logic [VALUE_BITS-1:0]   store_top;
    logic [VALUE_BITS-1:0]   store_mid;
    logic [VALUE_BITS-1:0]   store_right;
    logic                    res_push;
    logic [CW-1:0]           res_col;
    logic [ROW_W-1:0]        res_row;
    logic [VALUE_BITS-1:0]   res_value;
    logic [RES_W-1:0]        fifo_rdata;
    logic [FIFO_CNTW-1:0]    fifo_count;

    // input accepted only when the queue has room for every word in flight
    assign i_sample.ready = (fifo_count + FIFO_CNTW'(r_s1_ctl.valid))
                            <= FIFO_CNTW'(FIFO_DEPTH - 1);
    assign in_accept      = i_sample.valid && i_sample.ready;
    assign i_cfg.ready    = 1'b1;
    assign cfg_accept     = i_cfg.valid && i_cfg.ready;

    // configuration registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= calc_last_col(GRID_WIDTH_W'(RESET_WIDTH));
            r_last_row <= calc_last_row(GRID_HEIGHT_W'(RESET_HEIGHT));
            r_col      <= '0;
            r_row      <= '0;
        end else if (cfg_accept) begin
            case (i_cfg.index)
                REG_GRID_WIDTH: begin
                    r_last_col <= calc_last_col(i_cfg.data[GRID_WIDTH_W-1:0]);
                    r_col      <= '0;
                    r_row      <= '0;
                end
                REG_GRID_HEIGHT: begin
                    r_last_row <= calc_last_row(i_cfg.data[GRID_HEIGHT_W-1:0]);
                    r_col      <= '0;
                    r_row      <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_accept) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // input stage: the line store reads for this column and the next run in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl.valid    <= in_accept;
            r_s1_ctl.testable <= (r_row >= ROW_W'(2)) && (r_col != CW'(0)) &&
                                 (r_col != r_last_col);
            r_s1_ctl.row      <= r_row - ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_col    <= r_col;
            r_s1_sample <= i_sample.sample_value;
        end
    end

    assign next_col = r_col + CW'(1);

    // line store: upper half older row, lower half newer row
    glm_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2 * VALUE_BITS)
    ) u_line_store (
        .i_clk        (i_clk),
        .i_we         (r_s1_ctl.valid),
        .i_waddr      (r_s1_col),
        .i_wdata      ({store_mid, r_s1_sample}),
        .i_raddr      (r_col),
        .o_rdata      (store_rdata),
        .i_raddr_next (next_col),
        .o_rdata_next (store_right)
    );

    assign store_top = store_rdata[2*VALUE_BITS-1:VALUE_BITS];
    assign store_mid = store_rdata[VALUE_BITS-1:0];

    // neighbor compare
    glm_peak_test #(
        .CW         (CW),
        .VALUE_BITS (VALUE_BITS)
    ) u_peak_test (
        .i_clk        (i_clk),
        .i_ctl        (r_s1_ctl),
        .i_col        (r_s1_col),
        .i_bottom     (r_s1_sample),
        .i_centre     (store_mid),
        .i_top        (store_top),
        .i_right      (store_right),
        .o_push       (res_push),
        .o_peak_col   (res_col),
        .o_peak_row   (res_row),
        .o_peak_value (res_value)
    );

    // result queue and output word
    glm_result_fifo #(
        .DW    (RES_W),
        .DEPTH (FIFO_DEPTH),
        .PW    (FIFO_PW),
        .CNTW  (FIFO_CNTW)
    ) u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_col, res_row, res_value}),
        .i_pop   (o_peak.ready),
        .o_valid (o_peak.valid),
        .o_data  (fifo_rdata),
        .o_count (fifo_count)
    );

    assign o_peak.peak_column = fifo_rdata[RES_W-1:ROW_W+VALUE_BITS];
    assign o_peak.peak_row    = fifo_rdata[ROW_W+VALUE_BITS-1:VALUE_BITS];
    assign o_peak.peak_value  = fifo_rdata[VALUE_BITS-1:0];

endmodule
